// ===== hw/rtl/mcct_pkg.sv =====
package mcct_pkg;

  // result codes
  localparam logic [1:0] OUT_INSIDE  = 2'd0;
  localparam logic [1:0] OUT_CONTACT = 2'd1;
  localparam logic [1:0] OUT_NONE    = 2'd2;

  localparam int TIME_BITS = 32;
  localparam int MUL_CHUNK = 16;
  localparam int QDEPTH    = 4;

  // stages of the chunked multiplier for a multiplier operand of wb bits
  function automatic int mul_lat(input int wb);
    return (wb + MUL_CHUNK - 1) / MUL_CHUNK;
  endfunction

endpackage

// ===== hw/rtl/mcct_mul.sv =====
module mcct_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WA-1:0]        a,
  input  logic [WB-1:0]        b,
  output logic [WA+WB-1:0]     p
);
  import mcct_pkg::*;

  localparam int L  = mul_lat(WB);
  localparam int BP = L * MUL_CHUNK;
  localparam int PW = WA + WB;
  localparam int XW = WA + MUL_CHUNK;

  logic [PW-1:0] acc_r [L];
  logic [WA-1:0] a_r   [L];
  logic [BP-1:0] b_r   [L];

  logic [PW-1:0] acc_nxt [L];
  logic [XW-1:0] pp      [L];
  logic [BP-1:0] b_ext;

  assign b_ext = BP'(b);

  // one 16-bit slice of b per stage
  always_comb begin
    for (int k = 0; k < L; k++) begin
      if (k == 0) begin
        pp[k]      = XW'(a) * XW'(b_ext[MUL_CHUNK-1:0]);
        acc_nxt[k] = PW'(pp[k]);
      end else begin
        pp[k]      = XW'(a_r[k-1]) * XW'(b_r[k-1][k*MUL_CHUNK +: MUL_CHUNK]);
        acc_nxt[k] = acc_r[k-1] + (PW'(pp[k]) << (k * MUL_CHUNK));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L; k++) begin
        acc_r[k] <= acc_nxt[k];
        a_r[k]   <= (k == 0) ? a : a_r[k-1];
        b_r[k]   <= (k == 0) ? b_ext : b_r[k-1];
      end
    end
  end

  assign p = acc_r[L-1];

endmodule

// ===== hw/rtl/mcct_front.sv =====
module mcct_front #(
  parameter int CW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CW-1:0]             circle_x,
  input  logic [CW-1:0]             circle_z,
  input  logic [CW-1:0]             circle_vx,
  input  logic [CW-1:0]             circle_vz,
  input  logic [CW-1:0]             point_x,
  input  logic [CW-1:0]             point_z,
  input  logic [CW-1:0]             point_vx,
  input  logic [CW-1:0]             point_vz,
  input  logic [CW-2:0]             radius,
  input  logic                      fifo_full,
  output logic                      push,
  output logic [1:0]                fin_cls,
  output logic [2*(2*CW+3)-1:0]     fin_d,
  output logic [2*CW+2:0]           fin_m,
  output logic [2*CW+2:0]           fin_a
);
  import mcct_pkg::*;

  localparam int D  = CW + 1;
  localparam int PW = 2 * D + 1;
  localparam int DW = 2 * PW;
  localparam int L1 = mul_lat(D);
  localparam int L2 = mul_lat(PW);

  logic en;

  // stage A: relative position and velocity
  logic                va_r;
  logic signed [D-1:0] dx_r, dz_r, vx_r, vz_r;
  logic [CW-2:0]       r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= D'($signed(circle_x)) - D'($signed(point_x));
      dz_r <= D'($signed(circle_z)) - D'($signed(point_z));
      vx_r <= D'($signed(circle_vx)) - D'($signed(point_vx));
      vz_r <= D'($signed(circle_vz)) - D'($signed(point_vz));
      r_r  <= radius;
    end
  end

  logic [D-1:0] mdx, mdz, mvx, mvz;
  logic [1:0]   hneg;

  assign mdx = dx_r[D-1] ? D'(-dx_r) : D'(dx_r);
  assign mdz = dz_r[D-1] ? D'(-dz_r) : D'(dz_r);
  assign mvx = vx_r[D-1] ? D'(-vx_r) : D'(vx_r);
  assign mvz = vz_r[D-1] ? D'(-vz_r) : D'(vz_r);
  assign hneg = {dz_r[D-1] ^ vz_r[D-1], dx_r[D-1] ^ vx_r[D-1]};

  logic [2*D-1:0] sq_dx, sq_dz, sq_r, sq_vx, sq_vz, pr_x, pr_z;

  mcct_mul #(.WA(D), .WB(D)) u_mul_dx (.clk, .en, .a(mdx), .b(mdx), .p(sq_dx));
  mcct_mul #(.WA(D), .WB(D)) u_mul_dz (.clk, .en, .a(mdz), .b(mdz), .p(sq_dz));
  mcct_mul #(.WA(D), .WB(D)) u_mul_r  (.clk, .en, .a(D'(r_r)), .b(D'(r_r)), .p(sq_r));
  mcct_mul #(.WA(D), .WB(D)) u_mul_vx (.clk, .en, .a(mvx), .b(mvx), .p(sq_vx));
  mcct_mul #(.WA(D), .WB(D)) u_mul_vz (.clk, .en, .a(mvz), .b(mvz), .p(sq_vz));
  mcct_mul #(.WA(D), .WB(D)) u_mul_hx (.clk, .en, .a(mdx), .b(mvx), .p(pr_x));
  mcct_mul #(.WA(D), .WB(D)) u_mul_hz (.clk, .en, .a(mdz), .b(mvz), .p(pr_z));

  // side data alongside the first multipliers
  logic       b_v_r  [L1];
  logic [1:0] b_hn_r [L1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L1; k++) b_v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < L1; k++) b_v_r[k] <= (k == 0) ? va_r : b_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L1; k++) b_hn_r[k] <= (k == 0) ? hneg : b_hn_r[k-1];
    end
  end

  // stage C: quadratic coefficients and early classification
  logic [PW-1:0] p2, r2, a_sum, hp, hn;
  logic [1:0]    cls_c;

  always_comb begin
    p2    = PW'(sq_dx) + PW'(sq_dz);
    r2    = PW'(sq_r);
    a_sum = PW'(sq_vx) + PW'(sq_vz);
    hp    = (b_hn_r[L1-1][0] ? '0 : PW'(pr_x)) + (b_hn_r[L1-1][1] ? '0 : PW'(pr_z));
    hn    = (b_hn_r[L1-1][0] ? PW'(pr_x) : '0) + (b_hn_r[L1-1][1] ? PW'(pr_z) : '0);
    if (p2 <= r2) begin
      cls_c = OUT_INSIDE;
    end else if (a_sum == '0 || hp >= hn) begin
      cls_c = OUT_NONE;
    end else begin
      cls_c = OUT_CONTACT;
    end
  end

  logic          vc_r;
  logic [1:0]    clsc_r;
  logic [PW-1:0] mc_r, ac_r, cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= b_v_r[L1-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clsc_r <= cls_c;
      mc_r   <= hn - hp;
      ac_r   <= a_sum;
      cc_r   <= p2 - r2;
    end
  end

  logic [DW-1:0] m2, acp;

  mcct_mul #(.WA(PW), .WB(PW)) u_mul_m2 (.clk, .en, .a(mc_r), .b(mc_r), .p(m2));
  mcct_mul #(.WA(PW), .WB(PW)) u_mul_ac (.clk, .en, .a(ac_r), .b(cc_r), .p(acp));

  logic          e_v_r   [L2];
  logic [1:0]    e_cls_r [L2];
  logic [PW-1:0] e_m_r   [L2];
  logic [PW-1:0] e_a_r   [L2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L2; k++) e_v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < L2; k++) e_v_r[k] <= (k == 0) ? vc_r : e_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L2; k++) begin
        e_cls_r[k] <= (k == 0) ? clsc_r : e_cls_r[k-1];
        e_m_r[k]   <= (k == 0) ? mc_r   : e_m_r[k-1];
        e_a_r[k]   <= (k == 0) ? ac_r   : e_a_r[k-1];
      end
    end
  end

  // stage D: discriminant
  logic          vd_r;
  logic [1:0]    clsd_r;
  logic [DW-1:0] dd_r;
  logic [PW-1:0] md_r, ad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= e_v_r[L2-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clsd_r <= (e_cls_r[L2-1] == OUT_CONTACT && m2 <= acp) ? OUT_NONE : e_cls_r[L2-1];
      dd_r   <= m2 - acp;
      md_r   <= e_m_r[L2-1];
      ad_r   <= e_a_r[L2-1];
    end
  end

  // hold the whole front while its last item waits for queue space
  assign en       = !(vd_r && fifo_full);
  assign in_ready = en;
  assign push     = vd_r && !fifo_full;
  assign fin_cls  = clsd_r;
  assign fin_d    = dd_r;
  assign fin_m    = md_r;
  assign fin_a    = ad_r;

endmodule

// ===== hw/rtl/mcct_fifo.sv =====
module mcct_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         nempty,
  output logic [W-1:0] rdata
);
  import mcct_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= AW'(wp_r + 1'b1);
      if (pop)  rp_r <= AW'(rp_r + 1'b1);
      if (push && !pop) cnt_r <= CW'(cnt_r + 1'b1);
      else if (pop && !push) cnt_r <= CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
  end

  assign full   = (cnt_r == CW'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem[rp_r];

endmodule

// ===== hw/rtl/mcct_back.sv =====
module mcct_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [1:0]                q_cls,
  input  logic [2*(2*CW+3)-1:0]     q_d,
  input  logic [2*CW+2:0]           q_m,
  input  logic [2*CW+2:0]           q_a,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_outcome,
  output logic [mcct_pkg::TIME_BITS-1:0] out_contact_time
);
  import mcct_pkg::*;

  localparam int MW = 2 * CW + 3;
  localparam int DW = 2 * MW;
  localparam int RW = MW + 2;
  localparam int NW = MW + FB;
  localparam int QW = MW + 1;
  localparam int TB = TIME_BITS;

  logic en;

  // square root, one result bit per stage
  logic          sq_v_r    [MW];
  logic [1:0]    sq_cls_r  [MW];
  logic [DW-1:0] sq_d_r    [MW];
  logic [MW-1:0] sq_m_r    [MW];
  logic [MW-1:0] sq_a_r    [MW];
  logic [RW-1:0] sq_rem_r  [MW];
  logic [MW-1:0] sq_root_r [MW];

  logic          sq_v_in    [MW];
  logic [1:0]    sq_cls_in  [MW];
  logic [DW-1:0] sq_d_in    [MW];
  logic [MW-1:0] sq_m_in    [MW];
  logic [MW-1:0] sq_a_in    [MW];
  logic [RW-1:0] sq_rem_in  [MW];
  logic [MW-1:0] sq_root_in [MW];
  logic [RW-1:0] sq_sh      [MW];
  logic [RW-1:0] sq_trial   [MW];
  logic [RW-1:0] sq_rem_nxt [MW];
  logic [MW-1:0] sq_root_nxt[MW];
  logic          sq_ge      [MW];

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      if (i == 0) begin
        sq_v_in[i]    = q_valid;
        sq_cls_in[i]  = q_cls;
        sq_d_in[i]    = q_d;
        sq_m_in[i]    = q_m;
        sq_a_in[i]    = q_a;
        sq_rem_in[i]  = '0;
        sq_root_in[i] = '0;
      end else begin
        sq_v_in[i]    = sq_v_r[i-1];
        sq_cls_in[i]  = sq_cls_r[i-1];
        sq_d_in[i]    = sq_d_r[i-1];
        sq_m_in[i]    = sq_m_r[i-1];
        sq_a_in[i]    = sq_a_r[i-1];
        sq_rem_in[i]  = sq_rem_r[i-1];
        sq_root_in[i] = sq_root_r[i-1];
      end
      sq_sh[i]       = {sq_rem_in[i][RW-3:0], sq_d_in[i][DW-1-2*i -: 2]};
      sq_trial[i]    = {sq_root_in[i], 2'b01};
      sq_ge[i]       = (sq_sh[i] >= sq_trial[i]);
      sq_rem_nxt[i]  = sq_ge[i] ? (sq_sh[i] - sq_trial[i]) : sq_sh[i];
      sq_root_nxt[i] = {sq_root_in[i][MW-2:0], sq_ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MW; i++) sq_v_r[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < MW; i++) sq_v_r[i] <= sq_v_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < MW; i++) begin
        sq_cls_r[i]  <= sq_cls_in[i];
        sq_d_r[i]    <= sq_d_in[i];
        sq_m_r[i]    <= sq_m_in[i];
        sq_a_r[i]    <= sq_a_in[i];
        sq_rem_r[i]  <= sq_rem_nxt[i];
        sq_root_r[i] <= sq_root_nxt[i];
      end
    end
  end

  // numerator and saturation check
  logic          nv_r;
  logic [1:0]    ncls_r;
  logic [NW-1:0] nnum_r;
  logic [MW-1:0] na_r;
  logic          nsat_r;
  logic [MW-1:0] n_val;
  logic [NW-1:0] num;

  assign n_val = sq_m_r[MW-1] - sq_root_r[MW-1];
  assign num   = {n_val, {FB{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= sq_v_r[MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ncls_r <= sq_cls_r[MW-1];
      nnum_r <= num;
      na_r   <= sq_a_r[MW-1];
      nsat_r <= (num[NW-1:TB] >= sq_a_r[MW-1]);
    end
  end

  // long division, one quotient bit per stage
  logic          dv_v_r   [TB];
  logic [1:0]    dv_cls_r [TB];
  logic [NW-1:0] dv_num_r [TB];
  logic [MW-1:0] dv_a_r   [TB];
  logic          dv_sat_r [TB];
  logic [QW-1:0] dv_rem_r [TB];
  logic [TB-1:0] dv_q_r   [TB];

  logic          dv_v_in   [TB];
  logic [1:0]    dv_cls_in [TB];
  logic [NW-1:0] dv_num_in [TB];
  logic [MW-1:0] dv_a_in   [TB];
  logic          dv_sat_in [TB];
  logic [QW-1:0] dv_rem_in [TB];
  logic [TB-1:0] dv_q_in   [TB];
  logic [QW-1:0] dv_sh     [TB];
  logic          dv_ge     [TB];

  always_comb begin
    for (int j = 0; j < TB; j++) begin
      if (j == 0) begin
        dv_v_in[j]   = nv_r;
        dv_cls_in[j] = ncls_r;
        dv_num_in[j] = nnum_r;
        dv_a_in[j]   = na_r;
        dv_sat_in[j] = nsat_r;
        dv_rem_in[j] = QW'(nnum_r[NW-1:TB]);
        dv_q_in[j]   = '0;
      end else begin
        dv_v_in[j]   = dv_v_r[j-1];
        dv_cls_in[j] = dv_cls_r[j-1];
        dv_num_in[j] = dv_num_r[j-1];
        dv_a_in[j]   = dv_a_r[j-1];
        dv_sat_in[j] = dv_sat_r[j-1];
        dv_rem_in[j] = dv_rem_r[j-1];
        dv_q_in[j]   = dv_q_r[j-1];
      end
      dv_sh[j] = {dv_rem_in[j][QW-2:0], dv_num_in[j][TB-1-j]};
      dv_ge[j] = (dv_sh[j] >= QW'(dv_a_in[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TB; j++) dv_v_r[j] <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < TB; j++) dv_v_r[j] <= dv_v_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < TB; j++) begin
        dv_cls_r[j] <= dv_cls_in[j];
        dv_num_r[j] <= dv_num_in[j];
        dv_a_r[j]   <= dv_a_in[j];
        dv_sat_r[j] <= dv_sat_in[j];
        dv_rem_r[j] <= dv_ge[j] ? (dv_sh[j] - QW'(dv_a_in[j])) : dv_sh[j];
        dv_q_r[j]   <= {dv_q_in[j][TB-2:0], dv_ge[j]};
      end
    end
  end

  // last division stage doubles as the output register
  assign en        = !dv_v_r[TB-1] || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = dv_v_r[TB-1];
  assign out_outcome = dv_cls_r[TB-1];
  assign out_contact_time = (dv_cls_r[TB-1] != OUT_CONTACT) ? '0 :
                            (dv_sat_r[TB-1] ? '1 : dv_q_r[TB-1]);

endmodule

// ===== hw/rtl/moving_circle_contact_time.sv =====
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | circle, point, velocities, radius
// out_    | output    | out_valid / out_ready | outcome, contact_time
//
// One item per cycle sustained while out_ready stays high. Stages from input to out_valid:
// front: 11 stages through the coefficient multipliers; queue: 1; back: one stage per root
// bit, one for the numerator, one per quotient bit.
// A four-entry queue sits between the front and the back; each half stalls on its own.
// rst_n is synchronous and clears only valid bits and the queue pointers and count.
// out_ready low holds the back; a full queue then holds the front and in_ready.
module moving_circle_contact_time #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COORD_WIDTH-1:0]       in_circle_x,
  input  logic [COORD_WIDTH-1:0]       in_circle_z,
  input  logic [COORD_WIDTH-1:0]       in_circle_vx,
  input  logic [COORD_WIDTH-1:0]       in_circle_vz,
  input  logic [COORD_WIDTH-1:0]       in_point_x,
  input  logic [COORD_WIDTH-1:0]       in_point_z,
  input  logic [COORD_WIDTH-1:0]       in_point_vx,
  input  logic [COORD_WIDTH-1:0]       in_point_vz,
  input  logic [COORD_WIDTH-2:0]       in_radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_outcome,
  output logic [mcct_pkg::TIME_BITS-1:0] out_contact_time
);
  import mcct_pkg::*;

  localparam int MW = 2 * COORD_WIDTH + 3;
  localparam int DW = 2 * MW;
  localparam int EW = 2 + DW + 2 * MW;

  logic          push, full, pop, nempty;
  logic [1:0]    f_cls;
  logic [DW-1:0] f_d;
  logic [MW-1:0] f_m, f_a;
  logic [EW-1:0] rdata;

  mcct_front #(.CW(COORD_WIDTH)) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready,
    .circle_x(in_circle_x), .circle_z(in_circle_z),
    .circle_vx(in_circle_vx), .circle_vz(in_circle_vz),
    .point_x(in_point_x), .point_z(in_point_z),
    .point_vx(in_point_vx), .point_vz(in_point_vz),
    .radius(in_radius),
    .fifo_full(full), .push,
    .fin_cls(f_cls), .fin_d(f_d), .fin_m(f_m), .fin_a(f_a)
  );

  mcct_fifo #(.W(EW)) u_fifo (
    .clk, .rst_n,
    .push, .wdata({f_cls, f_d, f_m, f_a}), .full,
    .pop, .nempty, .rdata
  );

  mcct_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .q_valid(nempty),
    .q_cls(rdata[EW-1 -: 2]),
    .q_d(rdata[2*MW +: DW]),
    .q_m(rdata[MW +: MW]),
    .q_a(rdata[MW-1:0]),
    .q_pop(pop),
    .out_valid, .out_ready, .out_outcome, .out_contact_time
  );

endmodule
